[sv/pid_position_controller_defines.svh]
// Assertion macros for the position controller. Each one samples on the
// rising edge of clk and is disabled while rst_n is low.
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define PPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppc assertion failed");

// Next-cycle implication.
`define PPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppc assertion failed");

`else

`define PPC_ASSERT_IMP(lbl, ante, cons)
`define PPC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

[sv/ppc_pkg.sv]
`timescale 1ns / 1ps

package ppc_pkg;

    // Default number of fraction bits in the gains and the integral.
    localparam int unsigned GAIN_FRAC_BITS_DEF = 24;
    // Magnitude bound of the drive output.
    localparam int unsigned OUTPUT_LIMIT = 127;

    // Field and datapath widths.
    localparam int unsigned GAIN_W      = 32;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned POS_W       = 16;
    localparam int unsigned ERR_W       = POS_W + 1;
    localparam int unsigned ERR_MAG_W   = POS_W;
    localparam int unsigned DERR_W      = ERR_W + 1;
    localparam int unsigned DERR_MAG_W  = ERR_W;
    localparam int unsigned PROD_W      = GAIN_W + DERR_MAG_W;
    localparam int unsigned INTEG_W     = 48;
    localparam int unsigned INCR_CAP_LOG = 46;
    localparam int unsigned ACC_W       = INCR_CAP_LOG + 1;
    localparam int unsigned SUM_W       = 52;
    localparam int unsigned LIMIT_W     = 15;
    localparam int unsigned OUT_W       = 8;

    // Iteration counts: one quotient bit per step, one timestamp bit per step.
    localparam int unsigned DIV_STEPS = PROD_W;
    localparam int unsigned MUL_STEPS = TIME_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    // Configuration port.
    localparam int unsigned CFG_INDEX_W = 4;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P         = 4'd0,
        CFG_GAIN_I         = 4'd1,
        CFG_GAIN_D         = 4'd2,
        CFG_INTEGRAL_LIMIT = 4'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_P_RESET = 32'd1677722;
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET = 32'd16777;
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET = 32'd1677722;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd127;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ITER,
        ST_INTEG,
        ST_SUM_A,
        ST_SUM_B,
        ST_ROUND,
        ST_OUT
    } ppc_state_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic div_step;
        logic mul_step;
        logic integ;
        logic sum_a;
        logic sum_b;
        logic round;
        logic load_out;
    } ppc_cmd_t;

endpackage

[sv/ppc_sample_if.sv]
`timescale 1ns / 1ps

interface ppc_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [ppc_pkg::POS_W-1:0]    measured_value;
    logic        [ppc_pkg::TIME_W-1:0]   time_ms;
    logic                                load_target;
    logic signed [ppc_pkg::POS_W-1:0]    new_target;

    modport source (output valid, output measured_value, output time_ms,
                    output load_target, output new_target, input ready);
    modport sink   (input valid, input measured_value, input time_ms,
                    input load_target, input new_target, output ready);
endinterface

[sv/ppc_result_if.sv]
`timescale 1ns / 1ps

interface ppc_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [ppc_pkg::OUT_W-1:0]  drive_power;

    modport source (output valid, output drive_power, input ready);
    modport sink   (input valid, input drive_power, output ready);
endinterface

[sv/ppc_cfg_if.sv]
`timescale 1ns / 1ps

interface ppc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ppc_pkg::CFG_INDEX_W-1:0]      index;
    logic [ppc_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/ppc_ctrl.sv]
`timescale 1ns / 1ps
`include "pid_position_controller_defines.svh"

module ppc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output ppc_pkg::ppc_cmd_t cmd
);

    localparam logic [ppc_pkg::CNT_W-1:0] DIV_LAST =
        ppc_pkg::CNT_W'(ppc_pkg::DIV_STEPS - 1);
    localparam logic [ppc_pkg::CNT_W-1:0] MUL_COUNT =
        ppc_pkg::CNT_W'(ppc_pkg::MUL_STEPS);

    ppc_pkg::ppc_state_t          state_reg, state_next;
    logic [ppc_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         out_valid_reg, out_valid_next;

    // State, step counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        sample_ready   = 1'b0;
        cmd            = '0;

        // A waiting result leaves once its transfer completes.
        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ppc_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ppc_pkg::ST_PREP;
                end
            end
            ppc_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ppc_pkg::ST_MUL_P;
            end
            ppc_pkg::ST_MUL_P:
            begin
                cmd.mul_p  = 1'b1;
                state_next = ppc_pkg::ST_MUL_I;
            end
            ppc_pkg::ST_MUL_I:
            begin
                cmd.mul_i  = 1'b1;
                state_next = ppc_pkg::ST_MUL_D;
            end
            ppc_pkg::ST_MUL_D:
            begin
                cmd.mul_d  = 1'b1;
                cnt_next   = '0;
                state_next = ppc_pkg::ST_ITER;
            end
            ppc_pkg::ST_ITER:
            begin
                cmd.div_step = 1'b1;
                cmd.mul_step = (cnt_reg < MUL_COUNT);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ppc_pkg::ST_INTEG;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ppc_pkg::ST_INTEG:
            begin
                cmd.integ  = 1'b1;
                state_next = ppc_pkg::ST_SUM_A;
            end
            ppc_pkg::ST_SUM_A:
            begin
                cmd.sum_a  = 1'b1;
                state_next = ppc_pkg::ST_SUM_B;
            end
            ppc_pkg::ST_SUM_B:
            begin
                cmd.sum_b  = 1'b1;
                state_next = ppc_pkg::ST_ROUND;
            end
            ppc_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = ppc_pkg::ST_OUT;
            end
            ppc_pkg::ST_OUT:
            begin
                // Load the output register once it is free or being emptied.
                if (!out_valid_reg || result_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ppc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppc_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = out_valid_reg;

    `PPC_ASSERT_NXT(a_accept_starts_item, sample_valid && sample_ready, state_reg == ppc_pkg::ST_PREP)
    `PPC_ASSERT_IMP(a_iter_count_bound, state_reg == ppc_pkg::ST_ITER, cnt_reg <= DIV_LAST)
    `PPC_ASSERT_NXT(a_result_not_overwritten, (state_reg == ppc_pkg::ST_OUT) && out_valid_reg && !result_ready, (state_reg == ppc_pkg::ST_OUT) && out_valid_reg)
    `PPC_ASSERT_IMP(a_load_needs_room, cmd.load_out, !out_valid_reg || result_ready)

endmodule

[sv/ppc_datapath.sv]
`timescale 1ns / 1ps

module ppc_datapath #(
    parameter int unsigned GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ppc_pkg::ppc_cmd_t                    cmd,
    input  logic                                 cfg_valid,
    input  logic [ppc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [ppc_pkg::POS_W-1:0]            measured_value,
    input  logic [ppc_pkg::TIME_W-1:0]           time_ms,
    input  logic                                 load_target,
    input  logic [ppc_pkg::POS_W-1:0]            new_target,
    output logic [ppc_pkg::OUT_W-1:0]            drive_power
);

    localparam int unsigned POS_W      = ppc_pkg::POS_W;
    localparam int unsigned ERR_W      = ppc_pkg::ERR_W;
    localparam int unsigned DERR_W     = ppc_pkg::DERR_W;
    localparam int unsigned ERR_MAG_W  = ppc_pkg::ERR_MAG_W;
    localparam int unsigned DERR_MAG_W = ppc_pkg::DERR_MAG_W;
    localparam int unsigned GAIN_W     = ppc_pkg::GAIN_W;
    localparam int unsigned TIME_W     = ppc_pkg::TIME_W;
    localparam int unsigned PROD_W     = ppc_pkg::PROD_W;
    localparam int unsigned INTEG_W    = ppc_pkg::INTEG_W;
    localparam int unsigned ACC_W      = ppc_pkg::ACC_W;
    localparam int unsigned SUM_W      = ppc_pkg::SUM_W;
    localparam int unsigned OUT_W      = ppc_pkg::OUT_W;
    localparam int unsigned LIMIT_W    = ppc_pkg::LIMIT_W;

    localparam logic [PROD_W-1:0] INCR_CAP = PROD_W'(1) << ppc_pkg::INCR_CAP_LOG;
    localparam logic [SUM_W-1:0]  HALF_LSB = SUM_W'(1) << (GAIN_FRAC_BITS - 1);
    localparam logic [SUM_W-1:0]  OUT_MAX  = SUM_W'(ppc_pkg::OUTPUT_LIMIT);

    // Configuration registers.
    logic [GAIN_W-1:0]           gain_p_reg, gain_i_reg, gain_d_reg;
    logic [LIMIT_W-1:0]          limit_reg;

    // Controller state carried between items.
    logic [POS_W-1:0]            target_reg;
    logic [ERR_W-1:0]            prev_err_reg;
    logic [TIME_W-1:0]           prev_time_reg;
    logic signed [INTEG_W-1:0]   integral_reg;

    // Per-item working registers.
    logic [POS_W-1:0]            meas_reg;
    logic [TIME_W-1:0]           time_reg;
    logic [ERR_MAG_W-1:0]        err_mag_reg;
    logic                        err_neg_reg;
    logic [DERR_MAG_W-1:0]       derr_mag_reg;
    logic                        derr_neg_reg;
    logic [TIME_W-1:0]           dt_reg;
    logic                        dt_zero_reg;
    logic [INTEG_W-1:0]          prop_reg;
    logic [INTEG_W-1:0]          a_reg;
    logic [PROD_W-1:0]           dvd_reg;
    logic [TIME_W-1:0]           rem_reg;
    logic [TIME_W-1:0]           mul_dt_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic                        over_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]            rnd_reg;
    logic                        rnd_neg_reg;
    logic [OUT_W-1:0]            drive_reg;

    // Combinational values.
    logic [ERR_W-1:0]            err_w, err_abs;
    logic [DERR_W-1:0]           derr_w, derr_abs;
    logic [GAIN_W-1:0]           mul_a;
    logic [DERR_MAG_W-1:0]       mul_b;
    logic [PROD_W-1:0]           product;
    logic [PROD_W-1:0]           acc_next;
    logic [TIME_W:0]             rem_shift;
    logic                        rem_ge;
    logic [TIME_W-1:0]           rem_next;
    logic [ACC_W-1:0]            incr_mag;
    logic signed [INTEG_W-1:0]   incr_s, integral_sum_w, bound_s, integral_next;
    logic signed [SUM_W-1:0]     prop_s, deriv_s;
    logic [PROD_W-1:0]           deriv_mag;
    logic [SUM_W-1:0]            sum_abs, quot_w;
    logic [OUT_W-1:0]            sat_w, drive_next;
    ppc_pkg::cfg_index_t         cfg_sel;

    // Error, error change and their magnitudes.
    assign err_w    = {target_reg[POS_W-1], target_reg} - {meas_reg[POS_W-1], meas_reg};
    assign err_abs  = err_w[ERR_W-1] ? (ERR_W'(0) - err_w) : err_w;
    assign derr_w   = {err_w[ERR_W-1], err_w} - {prev_err_reg[ERR_W-1], prev_err_reg};
    assign derr_abs = derr_w[DERR_W-1] ? (DERR_W'(0) - derr_w) : derr_w;

    // Shared gain multiplier, used once for each of the three terms.
    always_comb
    begin
        priority if (cmd.mul_d)
        begin
            mul_a = gain_d_reg;
            mul_b = derr_mag_reg;
        end
        else if (cmd.mul_i)
        begin
            mul_a = gain_i_reg;
            mul_b = DERR_MAG_W'(err_mag_reg);
        end
        else
        begin
            mul_a = gain_p_reg;
            mul_b = DERR_MAG_W'(err_mag_reg);
        end
    end

    assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Serial multiply of the integral rate by dt, MSB first, saturating at the cap.
    assign acc_next = (PROD_W'(acc_reg) << 1)
                    + (mul_dt_reg[TIME_W-1] ? PROD_W'(a_reg) : PROD_W'(0));

    // Restoring divide step for the derivative term.
    assign rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dt_reg});
    assign rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, dt_reg}) : rem_shift[TIME_W-1:0];

    // Integral update and clamp.
    assign incr_mag       = over_reg ? ACC_W'(INCR_CAP) : acc_reg;
    assign incr_s         = err_neg_reg ? -$signed(INTEG_W'(incr_mag))
                                        : $signed(INTEG_W'(incr_mag));
    assign integral_sum_w = integral_reg + incr_s;
    assign bound_s        = $signed(INTEG_W'(limit_reg) << GAIN_FRAC_BITS);

    always_comb
    begin
        priority if (integral_sum_w > bound_s)
        begin
            integral_next = bound_s;
        end
        else if (integral_sum_w < -bound_s)
        begin
            integral_next = -bound_s;
        end
        else
        begin
            integral_next = integral_sum_w;
        end
    end

    // Signed proportional and derivative terms.
    assign prop_s    = err_neg_reg ? -$signed(SUM_W'(prop_reg)) : $signed(SUM_W'(prop_reg));
    assign deriv_mag = dt_zero_reg ? PROD_W'(0) : dvd_reg;
    assign deriv_s   = derr_neg_reg ? -$signed(SUM_W'(deriv_mag)) : $signed(SUM_W'(deriv_mag));

    // Rounding and saturation of the output.
    assign sum_abs    = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign quot_w     = rnd_reg >> GAIN_FRAC_BITS;
    assign sat_w      = (quot_w > OUT_MAX) ? OUT_W'(ppc_pkg::OUTPUT_LIMIT) : quot_w[OUT_W-1:0];
    assign drive_next = rnd_neg_reg ? (OUT_W'(0) - sat_w) : sat_w;

    assign cfg_sel = ppc_pkg::cfg_index_t'(cfg_index);

    // Configuration and state that survives between items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= ppc_pkg::GAIN_P_RESET;
            gain_i_reg    <= ppc_pkg::GAIN_I_RESET;
            gain_d_reg    <= ppc_pkg::GAIN_D_RESET;
            limit_reg     <= ppc_pkg::LIMIT_RESET;
            target_reg    <= '0;
            prev_err_reg  <= '0;
            prev_time_reg <= '0;
            integral_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_sel)
                    ppc_pkg::CFG_GAIN_P:         gain_p_reg <= GAIN_W'(cfg_data);
                    ppc_pkg::CFG_GAIN_I:         gain_i_reg <= GAIN_W'(cfg_data);
                    ppc_pkg::CFG_GAIN_D:         gain_d_reg <= GAIN_W'(cfg_data);
                    ppc_pkg::CFG_INTEGRAL_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:                     ;
                endcase
            end
            if (cmd.accept && load_target)
            begin
                target_reg   <= new_target;
                integral_reg <= '0;
            end
            if (cmd.prep)
            begin
                prev_err_reg  <= err_w;
                prev_time_reg <= time_reg;
            end
            if (cmd.integ)
            begin
                integral_reg <= integral_next;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            meas_reg <= measured_value;
            time_reg <= time_ms;
        end
        if (cmd.prep)
        begin
            err_mag_reg  <= err_abs[ERR_MAG_W-1:0];
            err_neg_reg  <= err_w[ERR_W-1];
            derr_mag_reg <= derr_abs[DERR_MAG_W-1:0];
            derr_neg_reg <= derr_w[DERR_W-1];
            dt_reg       <= time_reg - prev_time_reg;
            dt_zero_reg  <= (time_reg == prev_time_reg);
        end
        if (cmd.mul_p)
        begin
            prop_reg <= product[INTEG_W-1:0];
        end
        if (cmd.mul_i)
        begin
            a_reg <= product[INTEG_W-1:0];
        end
        if (cmd.mul_d)
        begin
            dvd_reg    <= product;
            rem_reg    <= '0;
            mul_dt_reg <= dt_reg;
            acc_reg    <= '0;
            over_reg   <= 1'b0;
        end
        if (cmd.mul_step)
        begin
            mul_dt_reg <= mul_dt_reg << 1;
            if (!over_reg)
            begin
                if (acc_next > INCR_CAP)
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    acc_reg <= acc_next[ACC_W-1:0];
                end
            end
        end
        if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[PROD_W-2:0], rem_ge};
        end
        if (cmd.sum_a)
        begin
            sum_reg <= prop_s + SUM_W'(integral_reg);
        end
        if (cmd.sum_b)
        begin
            sum_reg <= sum_reg + deriv_s;
        end
        if (cmd.round)
        begin
            rnd_reg     <= sum_abs + HALF_LSB;
            rnd_neg_reg <= sum_reg[SUM_W-1];
        end
        if (cmd.load_out)
        begin
            drive_reg <= drive_next;
        end
    end

    assign drive_power = drive_reg;

endmodule

[sv/pid_position_controller.sv]
`timescale 1ns / 1ps

// Position PID controller with a clamped integral. Each sample transfer
// brings a measured position, a millisecond timestamp and optionally a new
// target (loading a target clears the integral); each sample yields exactly
// one drive_power result, rounded half away from zero and saturated to
// +/-127. One sample is worked on at a time: the block takes no new sample
// until the result of the last one has been loaded into the output register.
// The derivative term is formed by a 49-step restoring divider; the serial
// multiply of the integral increment by dt runs alongside it in its first
// 32 steps, and one shared 32x17 multiplier forms the three gain products
// in consecutive cycles. A finished result waits in the output register
// while the next sample is taken in. Configuration writes are always taken
// and must only be issued while no sample is in flight.
module pid_position_controller #(
    parameter int unsigned GAIN_FRAC_BITS = ppc_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ppc_cfg_if.sink       cfg,
    ppc_sample_if.sink    sample,
    ppc_result_if.source  result
);

    ppc_pkg::ppc_cmd_t cmd;

    assign cfg.ready = 1'b1;

    // Sequencer.
    ppc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd)
    );

    // Arithmetic and state.
    ppc_datapath #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .measured_value (sample.measured_value),
        .time_ms        (sample.time_ms),
        .load_target    (sample.load_target),
        .new_target     (sample.new_target),
        .drive_power    (result.drive_power)
    );

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    import ppc_pkg::*;

    localparam int unsigned FRAC_BITS        = GAIN_FRAC_BITS_DEF;
    localparam int          PHASES           = 8;
    localparam int          ITEMS_PER_PHASE  = 130;
    localparam int          SETTLE_CYCLES    = 64;
    localparam int          LONG_HOLD_AT     = 350;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          STALL_LIMIT      = 4000;
    localparam int          PRINT_LIMIT      = 50;
    localparam int          STIM_ROWS        = 16;
    localparam logic [63:0] INCR_CAP         = 64'd1 << INCR_CAP_LOG;

    typedef struct packed {
        logic signed [POS_W-1:0] measured_value;
        logic [TIME_W-1:0]       time_ms;
        logic                    load_target;
        logic signed [POS_W-1:0] new_target;
    } sample_t;

    typedef struct packed {
        logic signed [POS_W-1:0] measured_value;
        logic [TIME_W-1:0]       time_ms;
        logic                    load_target;
        logic signed [POS_W-1:0] new_target;
        logic                    fixed;
        logic signed [OUT_W-1:0] drive_power;
    } stim_row_t;

    // Directed samples under the reset gains. A row with fixed set carries
    // its drive power by hand; the others are checked against the predictor.
    stim_row_t stim_table [STIM_ROWS] = '{
        // all zero on the first sample after reset
        '{16'sh0000, 32'h0000_0000, 1'b1, 16'sh0000, 1'b1, 8'sh00},
        // largest positive error saturates high
        '{16'sh8000, 32'h0000_0014, 1'b1, 16'sh7FFF, 1'b1, 8'sh7F},
        // largest negative error saturates low
        '{16'sh7FFF, 32'h0000_0028, 1'b1, 16'sh8000, 1'b1, 8'sh81},
        // repeated timestamp: no derivative, integral held
        '{16'sh7FFF, 32'h0000_0028, 1'b0, 16'sh0000, 1'b1, 8'sh81},
        // zero error right after a full swing
        '{16'sh0000, 32'h0000_003C, 1'b1, 16'sh0000, 1'b0, 8'sh00},
        '{16'sh0000, 32'h0000_0050, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        '{16'shFF9C, 32'h0000_0064, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        // timestamp goes backwards
        '{16'shFF9C, 32'h0000_0063, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        '{16'sh0005, 32'hFFFF_FFF0, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        // timestamp wraps past zero
        '{16'sh0005, 32'h0000_0004, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        '{16'sh7FFF, 32'h0000_0018, 1'b1, 16'sh7FFF, 1'b0, 8'sh00},
        '{16'shFFFF, 32'h0000_002C, 1'b1, 16'sh0000, 1'b0, 8'sh00},
        '{16'sh0001, 32'h0000_0040, 1'b0, 16'sh0000, 1'b0, 8'sh00},
        '{16'sh8000, 32'hFFFF_FFFF, 1'b1, 16'sh8000, 1'b0, 8'sh00},
        '{16'sh5555, 32'hFFFF_FFFF, 1'b0, 16'shAAAA, 1'b0, 8'sh00},
        '{16'shAAAA, 32'h8000_0000, 1'b1, 16'sh5555, 1'b0, 8'sh00}
    };

    logic clk;
    logic rst_n;

    ppc_cfg_if    cfg_bus ();
    ppc_sample_if sample_bus ();
    ppc_result_if result_bus ();

    pid_position_controller u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .sample (sample_bus),
        .result (result_bus)
    );

    // Mirror of the configuration registers.
    logic [GAIN_W-1:0]  cfg_gain_p = GAIN_P_RESET;
    logic [GAIN_W-1:0]  cfg_gain_i = GAIN_I_RESET;
    logic [GAIN_W-1:0]  cfg_gain_d = GAIN_D_RESET;
    logic [LIMIT_W-1:0] cfg_limit  = LIMIT_RESET;

    // Mirror of the controller state.
    logic signed [POS_W-1:0] ctl_target    = '0;
    logic signed [ERR_W-1:0] ctl_prev_err  = '0;
    logic [TIME_W-1:0]       ctl_prev_time = '0;
    longint                  ctl_integral  = 0;

    logic signed [OUT_W-1:0] drive_expect_q [$];
    logic signed [OUT_W-1:0] drive_want;

    int error_count      = 0;
    int stall_cycles     = 0;
    int samples_accepted = 0;
    bit quiet_tail       = 1'b0;
    bit long_hold_done   = 1'b0;

    // Works out the drive power for one sample and advances the mirror state.
    function automatic logic signed [OUT_W-1:0] predict_drive(input sample_t s);
        logic signed [ERR_W-1:0]  err;
        logic signed [DERR_W-1:0] derr;
        logic [TIME_W-1:0]        dt;
        logic [ERR_MAG_W-1:0]     err_mag;
        logic [DERR_MAG_W-1:0]    derr_mag;
        logic [95:0]              incr_full;
        logic [63:0]              prop_mag;
        logic [63:0]              incr_mag;
        logic [63:0]              deriv_mag;
        logic [63:0]              sum_mag;
        logic [63:0]              rounded;
        longint                   prop;
        longint                   deriv;
        longint                   sum;
        longint                   bound;

        if (s.load_target)
        begin
            ctl_target   = s.new_target;
            ctl_integral = 0;
        end

        err      = {ctl_target[POS_W-1], ctl_target}
                 - {s.measured_value[POS_W-1], s.measured_value};
        derr     = {err[ERR_W-1], err} - {ctl_prev_err[ERR_W-1], ctl_prev_err};
        dt       = s.time_ms - ctl_prev_time;
        err_mag  = err[ERR_W-1] ? ERR_MAG_W'(-err) : ERR_MAG_W'(err);
        derr_mag = derr[DERR_W-1] ? DERR_MAG_W'(-derr) : DERR_MAG_W'(derr);

        // Proportional term.
        prop_mag = 64'(cfg_gain_p) * 64'(err_mag);
        prop     = err[ERR_W-1] ? -longint'(prop_mag) : longint'(prop_mag);

        // Integral increment saturates at the cap, then the sum is clamped.
        incr_full = 96'(cfg_gain_i) * 96'(err_mag) * 96'(dt);
        incr_mag  = (incr_full > 96'(INCR_CAP)) ? INCR_CAP : 64'(incr_full);
        ctl_integral = ctl_integral
                     + (err[ERR_W-1] ? -longint'(incr_mag) : longint'(incr_mag));
        bound = longint'(64'(cfg_limit) << FRAC_BITS);
        if (ctl_integral > bound)
            ctl_integral = bound;
        else if (ctl_integral < -bound)
            ctl_integral = -bound;

        // Derivative term, truncated toward zero; none when dt is zero.
        deriv_mag = (dt == '0) ? 64'd0 : (64'(cfg_gain_d) * 64'(derr_mag)) / 64'(dt);
        deriv     = derr[DERR_W-1] ? -longint'(deriv_mag) : longint'(deriv_mag);

        // Round half away from zero, then saturate.
        sum     = prop + ctl_integral + deriv;
        sum_mag = (sum < 0) ? 64'(-sum) : 64'(sum);
        rounded = (sum_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (rounded > 64'(OUTPUT_LIMIT))
            rounded = 64'(OUTPUT_LIMIT);

        ctl_prev_err  = err;
        ctl_prev_time = s.time_ms;
        return (sum < 0) ? -OUT_W'(rounded) : OUT_W'(rounded);
    endfunction

    task automatic report_mismatch(input string what);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Offers one sample until it transfers, then records its expected result.
    task automatic send_sample(input sample_t s, input bit fixed,
                               input logic signed [OUT_W-1:0] fixed_drive,
                               input bit park);
        logic signed [OUT_W-1:0] predicted;

        sample_bus.valid          <= 1'b1;
        sample_bus.measured_value <= s.measured_value;
        sample_bus.time_ms        <= s.time_ms;
        sample_bus.load_target    <= s.load_target;
        sample_bus.new_target     <= s.new_target;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        predicted = predict_drive(s);
        drive_expect_q.push_back(fixed ? fixed_drive : predicted);
        if (park)
        begin
            sample_bus.valid <= 1'b0;
        end
        else if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    // Writes all four registers back to back and updates the mirror.
    task automatic load_settings(input logic [31:0] gain_p, input logic [31:0] gain_i,
                                 input logic [31:0] gain_d, input logic [31:0] limit);
        logic [31:0] value [4];

        value = '{gain_p, gain_i, gain_d, limit};
        cfg_bus.valid <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            cfg_bus.index <= cfg_index_t'(k);
            cfg_bus.data  <= value[k];
            do
                @(posedge clk);
            while (!cfg_bus.ready);
            case (cfg_index_t'(k))
                CFG_GAIN_P:         cfg_gain_p = value[k];
                CFG_GAIN_I:         cfg_gain_i = value[k];
                CFG_GAIN_D:         cfg_gain_d = value[k];
                CFG_INTEGRAL_LIMIT: cfg_limit  = value[k][LIMIT_W-1:0];
                default:            ;
            endcase
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Waits for every expected result, then lets the block settle.
    task automatic drain;
        while (drive_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: short random stalls, one long hold-off, none at the tail.
    initial
    begin
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && samples_accepted >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                result_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // Result check and transfer bookkeeping.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected drive_power %0d",
                                              result_bus.drive_power));
                end
                else
                begin
                    drive_want = drive_expect_q.pop_front();
                    if (result_bus.drive_power !== drive_want)
                        report_mismatch($sformatf("drive_power %0d, expected %0d",
                                                  result_bus.drive_power, drive_want));
                end
            end
            if (sample_bus.valid && sample_bus.ready)
                samples_accepted <= samples_accepted + 1;
            if ((sample_bus.valid && sample_bus.ready)
                || (result_bus.valid && result_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // Stimulus.
    initial
    begin
        sample_t           item;
        logic signed [15:0] gen_target;
        logic [31:0]       gen_time;
        logic [31:0]       step;
        int                pick;
        int                span;

        rst_n                     <= 1'b0;
        sample_bus.valid          <= 1'b0;
        sample_bus.measured_value <= '0;
        sample_bus.time_ms        <= '0;
        sample_bus.load_target    <= 1'b0;
        sample_bus.new_target     <= '0;
        cfg_bus.valid             <= 1'b0;
        cfg_bus.index             <= CFG_GAIN_P;
        cfg_bus.data              <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows under the reset gains.
        for (int r = 0; r < STIM_ROWS; r++)
        begin
            item = '{stim_table[r].measured_value, stim_table[r].time_ms,
                     stim_table[r].load_target, stim_table[r].new_target};
            send_sample(item, stim_table[r].fixed, stim_table[r].drive_power,
                        r == STIM_ROWS - 1);
        end
        drain();

        gen_target = '0;
        gen_time   = $urandom;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: load_settings(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET,
                                 32'(LIMIT_RESET));
                1: load_settings(32'd0, 32'd0, 32'd0, 32'd0);
                2: load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF);
                // Pure half gain: every odd error lands exactly on a half.
                3: load_settings(32'h0080_0000, 32'd0, 32'd0, 32'($urandom_range(0, 32767)));
                4: load_settings(32'h0100_0000, 32'h0010_0000, 32'h0100_0000, 32'd100);
                default:
                    load_settings(($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 32'h0200_0000),
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 32'h0004_0000),
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                                              : $urandom_range(0, 32'h0200_0000),
                                  32'($urandom_range(0, 32767)));
            endcase
            if (phase == PHASES - 1)
                quiet_tail = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Mostly regular sample periods, some repeats, jumps and steps back.
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    step = $urandom_range(1, 40);
                else if (pick < 16)
                    step = 32'd0;
                else if (pick < 18)
                    step = $urandom;
                else
                    step = -32'($urandom_range(1, 1000));
                gen_time = gen_time + step;

                item.time_ms     = gen_time;
                item.load_target = ($urandom_range(0, 7) == 0);
                item.new_target  = ($urandom_range(0, 1) == 0)
                                 ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
                if (item.load_target)
                    gen_target = item.new_target;

                // Measured position mostly near the target, sometimes anywhere.
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    span = 16;
                else if (pick < 15)
                    span = 512;
                else
                    span = 4096;
                if (pick < 18)
                    item.measured_value = 16'(int'(gen_target)
                                        - (int'($urandom_range(0, 2 * span)) - span));
                else
                    item.measured_value = 16'($urandom);

                send_sample(item, 1'b0, '0, n == ITEMS_PER_PHASE - 1);
            end
            drain();
        end

        if (drive_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", drive_expect_q.size()));
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
